@@ hw/rtl/vmt_pkg.sv @@
package vmt_pkg;

    // Fixed field widths
    localparam int VMT_ELEM_W  = 32;
    localparam int VMT_LANES   = 4;
    localparam int VMT_TERMS   = 4;
    localparam int VMT_PAIRS   = 8;
    localparam int VMT_ELEMS   = 2 * VMT_PAIRS;
    localparam int VMT_PAIR_W  = 2 * VMT_ELEM_W;
    localparam int VMT_IDX_W   = $clog2(VMT_PAIRS);
    localparam int VMT_PROD_W  = 2 * VMT_ELEM_W;
    localparam int VMT_HALF_W  = VMT_PROD_W + 1;
    localparam int VMT_SUM_W   = VMT_PROD_W + 2;
    localparam int VMT_TDATA_W = VMT_LANES * VMT_ELEM_W;

    localparam int VMT_FRAC_BITS_DEF = 16;

    typedef logic [VMT_ELEM_W-1:0] vmt_elem_t;

    // Input selector carried on tuser
    typedef enum logic [1:0] {
        VMT_MODE_FULL   = 2'd0,
        VMT_MODE_POINT  = 2'd1,
        VMT_MODE_UPPER3 = 2'd2,
        VMT_MODE_PACK3  = 2'd3
    } vmt_mode_t;

    // Load enables for the lane pipeline stages
    typedef struct packed {
        logic mul_en;
        logic half_en;
        logic sum_en;
        logic sat_en;
    } vmt_stage_en_t;

    // Identity matrix after reset
    localparam logic [VMT_PAIR_W-1:0] VMT_MATRIX_RESET [VMT_PAIRS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

@@ hw/rtl/vmt_lane.sv @@
module vmt_lane #(
    parameter int FRAC_BITS = vmt_pkg::VMT_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  vmt_pkg::vmt_stage_en_t en,
    input  vmt_pkg::vmt_elem_t     vec_i  [vmt_pkg::VMT_TERMS],
    input  vmt_pkg::vmt_elem_t     elem_i [vmt_pkg::VMT_TERMS],
    output vmt_pkg::vmt_elem_t     res_o,
    output logic                   sat_o
);
    import vmt_pkg::*;

    logic signed [VMT_PROD_W-1:0] vec_ext  [VMT_TERMS];
    logic signed [VMT_PROD_W-1:0] elem_ext [VMT_TERMS];
    logic signed [VMT_PROD_W-1:0] prod_reg [VMT_TERMS];
    logic signed [VMT_HALF_W-1:0] half_reg [2];
    logic signed [VMT_SUM_W-1:0]  sum_reg;
    logic signed [VMT_SUM_W-1:0]  shifted;
    logic [VMT_SUM_W-VMT_ELEM_W:0] upper;
    logic                         fits;
    vmt_elem_t                    res_next;
    vmt_elem_t                    res_reg;
    logic                         sat_next;
    logic                         sat_reg;

    // Sign-extend operands to the full product width
    always_comb begin
        for (int i = 0; i < VMT_TERMS; i++) begin
            vec_ext[i]  = VMT_PROD_W'($signed(vec_i[i]));
            elem_ext[i] = VMT_PROD_W'($signed(elem_i[i]));
        end
    end

    // Multiply, then sum the products exactly over two adder stages
    always_ff @(posedge aclk) begin
        if (en.mul_en) begin
            for (int i = 0; i < VMT_TERMS; i++) begin
                prod_reg[i] <= vec_ext[i] * elem_ext[i];
            end
        end
        if (en.half_en) begin
            half_reg[0] <= VMT_HALF_W'(prod_reg[0]) + VMT_HALF_W'(prod_reg[1]);
            half_reg[1] <= VMT_HALF_W'(prod_reg[2]) + VMT_HALF_W'(prod_reg[3]);
        end
        if (en.sum_en) begin
            sum_reg <= VMT_SUM_W'(half_reg[0]) + VMT_SUM_W'(half_reg[1]);
        end
        if (en.sat_en) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    // Drop the fraction (floor) and clip to the element range
    always_comb begin
        shifted = sum_reg >>> FRAC_BITS;
        upper   = shifted[VMT_SUM_W-1:VMT_ELEM_W-1];
        fits    = (&upper) | ~(|upper);
        if (fits) begin
            res_next = shifted[VMT_ELEM_W-1:0];
            sat_next = 1'b0;
        end else if (shifted[VMT_SUM_W-1]) begin
            res_next = {1'b1, {(VMT_ELEM_W-1){1'b0}}};
            sat_next = 1'b1;
        end else begin
            res_next = {1'b0, {(VMT_ELEM_W-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    assign res_o = res_reg;
    assign sat_o = sat_reg;

endmodule

@@ hw/rtl/vmt_merge.sv @@
module vmt_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic                                in_three,
    input  vmt_pkg::vmt_elem_t                  res_i [vmt_pkg::VMT_LANES],
    input  logic [vmt_pkg::VMT_LANES-1:0]       sat_i,
    output logic                                out_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [vmt_pkg::VMT_TDATA_W-1:0]     m_tdata,
    // saturated [0]
    output logic                                m_tuser
);
    import vmt_pkg::*;

    logic                   tvalid_reg;
    logic [VMT_TDATA_W-1:0] tdata_reg;
    logic [VMT_TDATA_W-1:0] tdata_next;
    logic                   tuser_reg;
    logic                   tuser_next;

    assign out_ready = ~tvalid_reg | m_tready;

    // Combine lane results; the fourth lane is dropped in three-component modes
    always_comb begin
        for (int j = 0; j < VMT_LANES; j++) begin
            tdata_next[j*VMT_ELEM_W +: VMT_ELEM_W] = res_i[j];
        end
        tuser_next = |sat_i[VMT_LANES-2:0];
        if (in_three) begin
            tdata_next[(VMT_LANES-1)*VMT_ELEM_W +: VMT_ELEM_W] = '0;
        end else begin
            tuser_next = tuser_next | sat_i[VMT_LANES-1];
        end
    end

    // Hold the transaction until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            tvalid_reg <= in_valid;
        end
        if (out_ready) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

@@ hw/rtl/vector_matrix_transform.sv @@
// Path from an accepted input transaction to m_tvalid: multiply, two adder stages,
// shift and clip in the lanes, merge into the output register.
// Throughput: one transaction per cycle while the output is not stalled; four lanes,
// one per result component, each with four 32x32 multipliers, so every item is
// taken in a single pass. Reset (aresetn low at a clock edge) empties the pipeline
// and loads the identity matrix into the configuration registers.
module vector_matrix_transform #(
    parameter int FRAC_BITS = vmt_pkg::VMT_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
    input  logic [vmt_pkg::VMT_TDATA_W-1:0]    s_tdata,
    // mode [1:0]
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [vmt_pkg::VMT_TDATA_W-1:0]    m_tdata,
    // saturated [0]
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vmt_pkg::VMT_IDX_W-1:0]      cfg_index,
    input  logic [vmt_pkg::VMT_PAIR_W-1:0]     cfg_data
);
    import vmt_pkg::*;

    localparam vmt_elem_t W_ONE = VMT_ELEM_W'(1) << FRAC_BITS;

    logic [VMT_PAIR_W-1:0] matrix_reg [VMT_PAIRS];
    vmt_elem_t             elem       [VMT_ELEMS];
    vmt_elem_t             vec_sel    [VMT_TERMS];
    vmt_elem_t             lane_elem  [VMT_LANES][VMT_TERMS];
    vmt_elem_t             lane_res   [VMT_LANES];
    logic [VMT_LANES-1:0]  lane_sat;
    vmt_mode_t             mode;
    logic                  stride3;
    logic                  three_in;

    logic mul_vld_reg, half_vld_reg, sum_vld_reg, sat_vld_reg;
    logic mul_three_reg, half_three_reg, sum_three_reg, sat_three_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    vmt_stage_en_t stage_en;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VMT_PAIRS; k++) begin
                matrix_reg[k] <= VMT_MATRIX_RESET[k];
            end
        end else if (cfg_valid) begin
            matrix_reg[cfg_index] <= cfg_data;
        end
    end

    // Split pairs into sixteen elements
    always_comb begin
        for (int k = 0; k < VMT_PAIRS; k++) begin
            elem[2*k]   = matrix_reg[k][VMT_ELEM_W-1:0];
            elem[2*k+1] = matrix_reg[k][VMT_PAIR_W-1:VMT_ELEM_W];
        end
    end

    // Decode the mode into the fourth vector term, the row stride and the three-component flag
    always_comb begin
        mode = vmt_mode_t'(s_tuser);
        for (int i = 0; i < VMT_TERMS; i++) begin
            vec_sel[i] = s_tdata[i*VMT_ELEM_W +: VMT_ELEM_W];
        end
        stride3  = 1'b0;
        three_in = 1'b0;
        case (mode)
            VMT_MODE_FULL: begin
            end
            VMT_MODE_POINT: begin
                vec_sel[VMT_TERMS-1] = W_ONE;
            end
            VMT_MODE_UPPER3: begin
                vec_sel[VMT_TERMS-1] = '0;
                three_in = 1'b1;
            end
            VMT_MODE_PACK3: begin
                vec_sel[VMT_TERMS-1] = '0;
                three_in = 1'b1;
                stride3  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Route column j of the matrix to lane j
    always_comb begin
        for (int j = 0; j < VMT_LANES; j++) begin
            for (int i = 0; i < VMT_TERMS; i++) begin
                lane_elem[j][i] = stride3 ? elem[i*3+j] : elem[i*4+j];
            end
        end
    end

    // Stage ready chain: a stage loads when empty or when its successor loads
    assign rdy4 = ~sat_vld_reg  | rdy5;
    assign rdy3 = ~sum_vld_reg  | rdy4;
    assign rdy2 = ~half_vld_reg | rdy3;
    assign rdy1 = ~mul_vld_reg  | rdy2;
    assign s_tready = rdy1;

    assign stage_en.mul_en  = rdy1;
    assign stage_en.half_en = rdy2;
    assign stage_en.sum_en  = rdy3;
    assign stage_en.sat_en  = rdy4;

    // Advance valid flags and the three-component flag with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg  <= 1'b0;
            half_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            sat_vld_reg  <= 1'b0;
        end else begin
            if (rdy1) mul_vld_reg  <= s_tvalid;
            if (rdy2) half_vld_reg <= mul_vld_reg;
            if (rdy3) sum_vld_reg  <= half_vld_reg;
            if (rdy4) sat_vld_reg  <= sum_vld_reg;
        end
        if (rdy1) mul_three_reg  <= three_in;
        if (rdy2) half_three_reg <= mul_three_reg;
        if (rdy3) sum_three_reg  <= half_three_reg;
        if (rdy4) sat_three_reg  <= sum_three_reg;
    end

    for (genvar j = 0; j < VMT_LANES; j++) begin : g_lane
        vmt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (stage_en),
            .vec_i  (vec_sel),
            .elem_i (lane_elem[j]),
            .res_o  (lane_res[j]),
            .sat_o  (lane_sat[j])
        );
    end

    vmt_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sat_vld_reg),
        .in_three  (sat_three_reg),
        .res_i     (lane_res),
        .sat_i     (lane_sat),
        .out_ready (rdy5),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ test/tb_vector_matrix_transform.sv @@
module tb_vector_matrix_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import vmt_pkg::*;

    localparam int FRAC         = VMT_FRAC_BITS_DEF;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int IDLE_PERCENT = 26;

    localparam logic signed [67:0] SAT_HIGH = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] SAT_LOW  = -68'sh8000_0000;

    // One output vertex: comp[0] is out_x, comp[3] is out_w
    typedef struct packed {
        logic [3:0][VMT_ELEM_W-1:0] comp;
        logic                       saturated;
    } xform_result_t;

    // Fixed matrices loaded ahead of directed rows
    typedef enum logic [2:0] {
        MAT_IDENT,
        MAT_MAX,
        MAT_MIN,
        MAT_HALF,
        MAT_ZERO
    } mat_preset_t;

    // Spread of random fixed-point values
    typedef enum logic [1:0] {
        MIX_SMALL,
        MIX_WIDE,
        MIX_BLEND,
        MIX_EDGE
    } value_mix_t;

    typedef struct packed {
        mat_preset_t                preset;
        vmt_mode_t                  mode;
        logic [3:0][VMT_ELEM_W-1:0] vec;
        logic                       typed;
        xform_result_t              result;
    } vertex_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic [VMT_TDATA_W-1:0]    s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [VMT_TDATA_W-1:0]    m_tdata;
    logic                      m_tuser;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [VMT_IDX_W-1:0]      cfg_index = '0;
    logic [VMT_PAIR_W-1:0]     cfg_data = '0;

    logic [VMT_PAIR_W-1:0] matrix_shadow [VMT_PAIRS];
    xform_result_t         pending_results [$];
    vertex_row_t           vertex_rows [21];
    string                 lane_names [4] = '{"out_x", "out_y", "out_z", "out_w"};

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;

    vector_matrix_transform dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [3:0][VMT_ELEM_W-1:0] vec4(
        logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w
    );
        return {w, z, y, x};
    endfunction

    function automatic xform_result_t res4(
        logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w, logic sat
    );
        xform_result_t r;
        r.comp      = {w, z, y, x};
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] matrix_element(int idx);
        logic [VMT_PAIR_W-1:0] pair;
        pair = matrix_shadow[idx >> 1];
        return (idx & 1) ? pair[63:32] : pair[31:0];
    endfunction

    // Exact sum of products, floor shift by the fraction bits, clip to 32 bits
    function automatic xform_result_t transform_vertex(
        vmt_mode_t mode, logic [3:0][VMT_ELEM_W-1:0] vec
    );
        logic signed [31:0] term [4];
        logic signed [67:0] acc;
        logic signed [67:0] scaled;
        int                 rows;
        int                 stride;
        int                 lanes;
        int                 i;
        int                 j;
        xform_result_t      r;
        r      = '0;
        rows   = 4;
        stride = 4;
        lanes  = 4;
        for (i = 0; i < 4; i++) term[i] = vec[i];
        case (mode)
            VMT_MODE_POINT: begin
                term[3] = 32'sd1 <<< FRAC;
            end
            VMT_MODE_UPPER3: begin
                rows  = 3;
                lanes = 3;
            end
            VMT_MODE_PACK3: begin
                rows   = 3;
                stride = 3;
                lanes  = 3;
            end
            default: ;
        endcase
        for (j = 0; j < lanes; j++) begin
            acc = '0;
            for (i = 0; i < rows; i++) acc = acc + term[i] * matrix_element(i * stride + j);
            scaled = acc >>> FRAC;
            if (scaled > SAT_HIGH) begin
                r.comp[j]   = 32'h7FFF_FFFF;
                r.saturated = 1'b1;
            end else if (scaled < SAT_LOW) begin
                r.comp[j]   = 32'h8000_0000;
                r.saturated = 1'b1;
            end else begin
                r.comp[j] = scaled[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_value(value_mix_t mix);
        int roll;
        roll = $urandom_range(99);
        if (mix == MIX_BLEND) begin
            mix  = (roll < 40) ? MIX_SMALL : (roll < 70) ? MIX_WIDE : MIX_EDGE;
            roll = $urandom_range(99);
        end
        case (mix)
            // within about +/-16.0
            MIX_SMALL: return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
            MIX_WIDE:  return $urandom();
            default: begin
                case (roll % 5)
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
        endcase
    endfunction

    // Offer one vertex, hold until taken, then record what should come back
    task automatic send_vertex(
        vmt_mode_t mode, logic [3:0][VMT_ELEM_W-1:0] vec, logic typed, xform_result_t known
    );
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vec;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(typed ? known : transform_vertex(mode, vec));
        @(negedge aclk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_matrix(input logic [VMT_PAIR_W-1:0] pairs [VMT_PAIRS]);
        int start;
        int k;
        int idx;
        start = $urandom_range(VMT_PAIRS - 1);
        for (k = 0; k < VMT_PAIRS; k++) begin
            idx = (start + k) % VMT_PAIRS;
            cfg_valid <= 1'b1;
            cfg_index <= VMT_IDX_W'(idx);
            cfg_data  <= pairs[idx];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            matrix_shadow[idx] = pairs[idx];
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each result transaction against the oldest expectation
    always @(posedge aclk) begin : result_check
        xform_result_t got;
        xform_result_t want;
        int            j;
        if (aresetn && m_tvalid && m_tready) begin
            got.comp      = m_tdata;
            got.saturated = m_tuser;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: tdata=%h tuser=%b", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                for (j = 0; j < 4; j++) begin
                    if (got.comp[j] !== want.comp[j]) begin
                        $error("%s: expected %h, actual %h", lane_names[j],
                               want.comp[j], got.comp[j]);
                        mismatches++;
                    end
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [VMT_PAIR_W-1:0] pairs [VMT_PAIRS];
        mat_preset_t           loaded;
        value_mix_t            mix;
        int                    r;
        int                    k;
        int                    ph;
        int                    n;

        // Directed vertices; typed results only where obvious
        vertex_rows = '{
            // identity after reset
            '{MAT_IDENT, VMT_MODE_FULL,
              vec4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000), 1'b1,
              res4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000, 1'b0)},
            '{MAT_IDENT, VMT_MODE_FULL,
              vec4(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF), 1'b1,
              res4(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0)},
            '{MAT_IDENT, VMT_MODE_POINT,
              vec4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h1234_5678), 1'b1,
              res4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000, 1'b0)},
            '{MAT_IDENT, VMT_MODE_UPPER3,
              vec4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000), 1'b1,
              res4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_0000, 1'b0)},
            // stride-3 read of the identity: e0 and e5 are the only ones set
            '{MAT_IDENT, VMT_MODE_PACK3,
              vec4(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000), 1'b1,
              res4(32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 1'b0)},
            // largest positive elements: clip both ways
            '{MAT_MAX, VMT_MODE_FULL,
              vec4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
              res4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1)},
            '{MAT_MAX, VMT_MODE_FULL,
              vec4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
              res4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1)},
            // w stays zero and does not flag in three-component modes
            '{MAT_MAX, VMT_MODE_UPPER3,
              vec4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
              res4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1)},
            '{MAT_MAX, VMT_MODE_FULL,
              vec4(32'h0, 32'h0, 32'h0, 32'h0), 1'b1,
              res4(32'h0, 32'h0, 32'h0, 32'h0, 1'b0)},
            // translation row alone reaches the top without clipping
            '{MAT_MAX, VMT_MODE_POINT,
              vec4(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF), 1'b1,
              res4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0)},
            '{MAT_MAX, VMT_MODE_PACK3,
              vec4(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0), 1'b0, '0},
            // most negative elements
            '{MAT_MIN, VMT_MODE_FULL,
              vec4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
              res4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1)},
            '{MAT_MIN, VMT_MODE_PACK3,
              vec4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
              res4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1)},
            '{MAT_MIN, VMT_MODE_FULL,
              vec4(32'h0001_0000, 32'h0, 32'h0, 32'h0), 1'b1,
              res4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0)},
            '{MAT_MIN, VMT_MODE_POINT,
              vec4(32'h0, 32'h0, 32'h0, 32'h0), 1'b1,
              res4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0)},
            // one half everywhere: fractions floor toward minus infinity
            '{MAT_HALF, VMT_MODE_FULL,
              vec4(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0), 1'b0, '0},
            '{MAT_HALF, VMT_MODE_FULL,
              vec4(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0), 1'b0, '0},
            '{MAT_HALF, VMT_MODE_POINT,
              vec4(32'hFFFF_FFFD, 32'h0000_0005, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0, '0},
            '{MAT_HALF, VMT_MODE_UPPER3,
              vec4(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0), 1'b0, '0},
            // all-zero matrix
            '{MAT_ZERO, VMT_MODE_FULL,
              vec4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
              res4(32'h0, 32'h0, 32'h0, 32'h0, 1'b0)},
            '{MAT_ZERO, VMT_MODE_POINT,
              vec4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
              res4(32'h0, 32'h0, 32'h0, 32'h0, 1'b0)}
        };

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        matrix_shadow = VMT_MATRIX_RESET;
        @(negedge aclk);

        // Directed rows; reload the matrix whenever the preset changes
        loaded = MAT_IDENT;
        for (r = 0; r < $size(vertex_rows); r++) begin
            if (vertex_rows[r].preset != loaded) begin
                drain();
                for (k = 0; k < VMT_PAIRS; k++) begin
                    case (vertex_rows[r].preset)
                        MAT_IDENT: pairs[k] = VMT_MATRIX_RESET[k];
                        MAT_MAX:   pairs[k] = {2{32'h7FFF_FFFF}};
                        MAT_MIN:   pairs[k] = {2{32'h8000_0000}};
                        MAT_HALF:  pairs[k] = {2{32'h0000_8000}};
                        default:   pairs[k] = '0;
                    endcase
                end
                write_matrix(pairs);
                loaded = vertex_rows[r].preset;
            end
            send_vertex(vertex_rows[r].mode, vertex_rows[r].vec,
                        vertex_rows[r].typed, vertex_rows[r].result);
        end

        // Random phases, each with a fresh matrix
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            mix = value_mix_t'(ph % 4);
            for (k = 0; k < VMT_PAIRS; k++) pairs[k] = {pick_value(mix), pick_value(mix)};
            write_matrix(pairs);
            no_idle = (ph == 2);
            if (ph == 1) hold_requests++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_vertex(vmt_mode_t'($urandom_range(3)),
                            vec4(pick_value(MIX_BLEND), pick_value(MIX_BLEND),
                                 pick_value(MIX_BLEND), pick_value(MIX_BLEND)),
                            1'b0, '0);
            end
            no_idle = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
